FILE: hdl/cct_pkg.sv
// Shared constants for the cycle counter timebase block.
package cct_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int MHZ_W    = 10;
    localparam int SEC_W    = 45;
    localparam int PART_W   = 10;
    localparam int FIX_W    = 40;

    // Shared divider geometry
    localparam int DIVD_W   = 64;
    localparam int DVSR_W   = 20;
    localparam int CNT_W    = 7;

    localparam logic [MHZ_W-1:0]  MHZ_RESET  = 10'd168;
    localparam logic [DVSR_W-1:0] US_PER_SEC = 20'd1000000;
    localparam logic [DVSR_W-1:0] US_PER_MS  = 20'd1000;

    // Iterations per divider pass
    localparam logic [CNT_W-1:0] ITER_FULL  = 7'd64;
    localparam logic [CNT_W-1:0] ITER_MS    = 7'd20;
    localparam logic [CNT_W-1:0] ITER_DELTA = 7'd40;

    // Divider pass codes
    localparam logic [1:0] PASS_US    = 2'd0;
    localparam logic [1:0] PASS_SEC   = 2'd1;
    localparam logic [1:0] PASS_MS    = 2'd2;
    localparam logic [1:0] PASS_DELTA = 2'd3;

endpackage

FILE: hdl/cycle_counter_timebase.sv
// Cycle counter timebase: wrap tracking and cycle-to-time conversion.
//
// Input channel (in_valid / in_stall): one request per counter sample. kind 0
// asks for the time breakdown of the extended count, kind 1 for the cycle
// delta against reference_count. Every request updates the wrap counter.
// Output channel (out_valid / out_stall): one result per request; fields of
// the other kind read as zero.
// Config channel (cfg_valid / cfg_ready): writes clock_mhz; always ready. The
// user must write it only while the block is idle; the block does not enforce
// that. A rate of 0 is used as 1.
// Timing: one 20-bit-divisor restoring divider resolves one quotient bit per
// cycle. Kind 0 runs three passes (64 + 64 + 20 steps), kind 1 one 40-step
// pass. One request is in work at a time; in_stall is high from accept until
// the result moves to the output register. A finished result waits in the
// holding registers while the output register still holds a stalled result,
// and the block takes the next request once the output register has it.
// Reset clears the wrap count, the last sample and the output valid, and
// sets clock_mhz to 168.
module cycle_counter_timebase (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cct_pkg::MHZ_W-1:0]     clock_mhz,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [cct_pkg::SAMPLE_W-1:0]  counter_sample,
    input  logic [cct_pkg::SAMPLE_W-1:0]  reference_count,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cct_pkg::SEC_W-1:0]     seconds,
    output logic [cct_pkg::PART_W-1:0]    milliseconds,
    output logic [cct_pkg::PART_W-1:0]    microseconds,
    output logic [cct_pkg::SAMPLE_W-1:0]  total_us,
    output logic [cct_pkg::SAMPLE_W-1:0]  delta_cycles,
    output logic [cct_pkg::FIX_W-1:0]     delta_us_fixed
);
    import cct_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    // Control state
    logic [1:0]          state_reg, state_next;
    logic [1:0]          pass_reg, pass_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MHZ_W-1:0]    mhz_reg;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [SAMPLE_W-1:0] wrap_reg, wrap_next;
    logic                out_valid_reg, out_valid_next;

    // Divider datapath
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [DVSR_W-1:0]   rem_reg, rem_next;
    logic [DVSR_W-1:0]   dvsr_reg, dvsr_next;

    // Result holding registers
    logic                kind_reg, kind_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic [PART_W-1:0]   ms_reg, ms_next;
    logic [PART_W-1:0]   us_reg, us_next;
    logic [SAMPLE_W-1:0] tot_reg, tot_next;
    logic [SAMPLE_W-1:0] delta_reg, delta_next;
    logic [FIX_W-1:0]    fix_reg, fix_next;

    // Output registers
    logic [SEC_W-1:0]    o_sec_reg, o_sec_next;
    logic [PART_W-1:0]   o_ms_reg, o_ms_next;
    logic [PART_W-1:0]   o_us_reg, o_us_next;
    logic [SAMPLE_W-1:0] o_tot_reg, o_tot_next;
    logic [SAMPLE_W-1:0] o_delta_reg, o_delta_next;
    logic [FIX_W-1:0]    o_fix_reg, o_fix_next;

    logic                in_fire;
    logic                out_free;
    logic [MHZ_W-1:0]    mhz_eff;
    logic [SAMPLE_W-1:0] wrap_upd;
    logic [SAMPLE_W-1:0] diff_in;
    logic [DVSR_W:0]     trial;
    logic [DVSR_W+1:0]   sub;
    logic                ge;
    logic [DVSR_W-1:0]   rem_step;
    logic [DIVD_W-1:0]   quo_step;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mhz_eff   = (mhz_reg == '0) ? MHZ_W'(1) : mhz_reg;

    assign wrap_upd  = (counter_sample < prev_reg) ? wrap_reg + SAMPLE_W'(1) : wrap_reg;
    assign diff_in   = counter_sample - reference_count;

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[DIVD_W-1]};
    assign sub      = {1'b0, trial} - {2'b00, dvsr_reg};
    assign ge       = ~sub[DVSR_W+1];
    assign rem_step = ge ? sub[DVSR_W-1:0] : trial[DVSR_W-1:0];
    assign quo_step = {quo_reg[DIVD_W-2:0], ge};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvsr_next      = dvsr_reg;
        kind_next      = kind_reg;
        sec_next       = sec_reg;
        ms_next        = ms_reg;
        us_next        = us_reg;
        tot_next       = tot_reg;
        delta_next     = delta_reg;
        fix_next       = fix_reg;
        o_sec_next     = o_sec_reg;
        o_ms_next      = o_ms_reg;
        o_us_next      = o_us_reg;
        o_tot_next     = o_tot_reg;
        o_delta_next   = o_delta_reg;
        o_fix_next     = o_fix_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    wrap_next  = wrap_upd;
                    prev_next  = counter_sample;
                    kind_next  = kind;
                    delta_next = diff_in;
                    rem_next   = '0;
                    dvsr_next  = {{(DVSR_W-MHZ_W){1'b0}}, mhz_eff};
                    state_next = ST_DIV;
                    if (!kind)
                    begin
                        quo_next   = {wrap_upd, counter_sample};
                        count_next = ITER_FULL;
                        pass_next  = PASS_US;
                    end
                    else
                    begin
                        // delta << 8, left aligned so the quotient lands low
                        quo_next   = {diff_in, 8'd0, {(DIVD_W-FIX_W){1'b0}}};
                        count_next = ITER_DELTA;
                        pass_next  = PASS_DELTA;
                    end
                end
            end

            ST_DIV:
            begin
                quo_next   = quo_step;
                rem_next   = rem_step;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    case (pass_reg)
                        PASS_US:
                        begin
                            // total microseconds, then split off seconds
                            tot_next   = quo_step[SAMPLE_W-1:0];
                            quo_next   = quo_step;
                            rem_next   = '0;
                            dvsr_next  = US_PER_SEC;
                            count_next = ITER_FULL;
                            pass_next  = PASS_SEC;
                        end
                        PASS_SEC:
                        begin
                            // sub-second remainder is below 2^20
                            sec_next   = quo_step[SEC_W-1:0];
                            quo_next   = {rem_step, {(DIVD_W-DVSR_W){1'b0}}};
                            rem_next   = '0;
                            dvsr_next  = US_PER_MS;
                            count_next = ITER_MS;
                            pass_next  = PASS_MS;
                        end
                        PASS_MS:
                        begin
                            ms_next    = quo_step[PART_W-1:0];
                            us_next    = rem_step[PART_W-1:0];
                            state_next = ST_WRITE;
                        end
                        default:
                        begin
                            fix_next   = quo_step[FIX_W-1:0];
                            state_next = ST_WRITE;
                        end
                    endcase
                end
            end

            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (!kind_reg)
                    begin
                        o_sec_next   = sec_reg;
                        o_ms_next    = ms_reg;
                        o_us_next    = us_reg;
                        o_tot_next   = tot_reg;
                        o_delta_next = '0;
                        o_fix_next   = '0;
                    end
                    else
                    begin
                        o_sec_next   = '0;
                        o_ms_next    = '0;
                        o_us_next    = '0;
                        o_tot_next   = '0;
                        o_delta_next = delta_reg;
                        o_fix_next   = fix_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_US;
            count_reg     <= '0;
            mhz_reg       <= MHZ_RESET;
            prev_reg      <= '0;
            wrap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mhz_reg <= clock_mhz;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvsr_reg    <= dvsr_next;
        kind_reg    <= kind_next;
        sec_reg     <= sec_next;
        ms_reg      <= ms_next;
        us_reg      <= us_next;
        tot_reg     <= tot_next;
        delta_reg   <= delta_next;
        fix_reg     <= fix_next;
        o_sec_reg   <= o_sec_next;
        o_ms_reg    <= o_ms_next;
        o_us_reg    <= o_us_next;
        o_tot_reg   <= o_tot_next;
        o_delta_reg <= o_delta_next;
        o_fix_reg   <= o_fix_next;
    end

    assign out_valid      = out_valid_reg;
    assign seconds        = o_sec_reg;
    assign milliseconds   = o_ms_reg;
    assign microseconds   = o_us_reg;
    assign total_us       = o_tot_reg;
    assign delta_cycles   = o_delta_reg;
    assign delta_us_fixed = o_fix_reg;

`ifndef SYNTHESIS
    // Partial remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dvsr_reg && dvsr_reg != '0))
        else $error("divider remainder out of range");

    // A pass never runs with an exhausted step count
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (count_reg != '0))
        else $error("divider step count is zero");

    // A new result appears only from the write-out state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_WRITE))
        else $error("result without write-out");

    // Sub-second parts stay in range
    a_parts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_ms_reg < PART_W'(1000) && o_us_reg < PART_W'(1000)))
        else $error("millisecond or microsecond part out of range");
`endif

endmodule

FILE: tb/cycle_counter_timebase_tb.sv
// Self-checking testbench for the cycle counter timebase block.
`timescale 1ns / 1ps

module cycle_counter_timebase_tb;
    import cct_pkg::*;

    // Request kinds
    typedef enum logic {
        KIND_TIME  = 1'b0,
        KIND_DELTA = 1'b1
    } kind_e;

    typedef struct {
        kind_e                kind;
        logic [SAMPLE_W-1:0]  sample;
        logic [SAMPLE_W-1:0]  base;
    } request_t;

    typedef struct packed {
        logic [SEC_W-1:0]     seconds;
        logic [PART_W-1:0]    milliseconds;
        logic [PART_W-1:0]    microseconds;
        logic [SAMPLE_W-1:0]  total_us;
        logic [SAMPLE_W-1:0]  delta_cycles;
        logic [FIX_W-1:0]     delta_us_fixed;
    } timing_t;

    // One directed row; typed rows carry their expected result
    typedef struct packed {
        kind_e                kind;
        logic [SAMPLE_W-1:0]  sample;
        logic [SAMPLE_W-1:0]  base;
        logic                 typed;
        timing_t              result;
    } dir_row_t;

    localparam timing_t ALL_ZERO     = '0;
    localparam int      N_DIRECTED   = 17;
    localparam int      N_PHASES     = 5;
    localparam int      PHASE_ITEMS  = 300;
    localparam int      HOLD_CYCLES  = 700;
    localparam int      QUIET_LIMIT  = 20000;
    localparam int      TAIL_CYCLES  = 200;
    localparam int      MAX_PRINTED  = 60;

    // Directed table, walked after reset at the reset clock rate of 168 MHz
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        {KIND_DELTA, 32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ZERO},
        {KIND_TIME,  32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ZERO},
        {KIND_TIME,  32'd168,       32'h0000_0000, 1'b1,
            {45'd0, 10'd0, 10'd1, 32'd1, 32'd0, 40'd0}},
        {KIND_TIME,  32'd168000,    32'h0000_0000, 1'b1,
            {45'd0, 10'd1, 10'd0, 32'd1000, 32'd0, 40'd0}},
        {KIND_TIME,  32'd168000000, 32'h0000_0000, 1'b1,
            {45'd1, 10'd0, 10'd0, 32'd1000000, 32'd0, 40'd0}},
        {KIND_TIME,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ALL_ZERO},
        {KIND_DELTA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ALL_ZERO},
        // sample drops to zero: time request counts its own wrap
        {KIND_TIME,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        {KIND_DELTA, 32'h0000_0000, 32'h0000_0001, 1'b0, ALL_ZERO},
        {KIND_DELTA, 32'd5,         32'd10,        1'b0, ALL_ZERO},
        {KIND_DELTA, 32'd168,       32'h0000_0000, 1'b1,
            {45'd0, 10'd0, 10'd0, 32'd0, 32'd168, 40'd256}},
        // equal sample is not a wrap
        {KIND_TIME,  32'd168,       32'h0000_0000, 1'b0, ALL_ZERO},
        {KIND_TIME,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, ALL_ZERO},
        {KIND_DELTA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, ALL_ZERO},
        // delta request also advances the wrap count
        {KIND_DELTA, 32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ZERO},
        {KIND_TIME,  32'h0000_0001, 32'h0000_0000, 1'b0, ALL_ZERO},
        {KIND_DELTA, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ALL_ZERO}
    };

    // Per phase: clock rate (negative picks one at random), idle and stall odds
    localparam int PHASE_RATE  [N_PHASES] = '{1, 1000, 0, 1023, -1};
    localparam int PHASE_IDLE  [N_PHASES] = '{0, 88, 0, 12, 0};
    localparam int PHASE_STALL [N_PHASES] = '{0, 0, 88, 12, 0};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MHZ_W-1:0]     clock_mhz;
    logic                 in_valid;
    logic                 in_stall;
    logic                 kind;
    logic [SAMPLE_W-1:0]  counter_sample;
    logic [SAMPLE_W-1:0]  reference_count;
    logic                 out_valid;
    logic                 out_stall;
    logic [SEC_W-1:0]     seconds;
    logic [PART_W-1:0]    milliseconds;
    logic [PART_W-1:0]    microseconds;
    logic [SAMPLE_W-1:0]  total_us;
    logic [SAMPLE_W-1:0]  delta_cycles;
    logic [FIX_W-1:0]     delta_us_fixed;

    // Timebase state mirrored by the predictor
    logic [SAMPLE_W-1:0]  last_sample;
    logic [SAMPLE_W-1:0]  wrap_count;
    logic [MHZ_W-1:0]     rate_setting;

    timing_t              pending_results [$];
    int                   error_count;
    int                   time_requests;
    int                   delta_requests;
    int                   rate_writes;
    int                   sender_idle_pct;
    int                   receiver_stall_pct;
    int                   hold_left;
    int                   quiet_cycles;
    logic [SAMPLE_W-1:0]  counter_now;

    cycle_counter_timebase dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .clock_mhz       (clock_mhz),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .counter_sample  (counter_sample),
        .reference_count (reference_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .seconds         (seconds),
        .milliseconds    (milliseconds),
        .microseconds    (microseconds),
        .total_us        (total_us),
        .delta_cycles    (delta_cycles),
        .delta_us_fixed  (delta_us_fixed)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Advance the wrap tracker by one sample and compute the resulting timing
    function automatic timing_t advance_timebase(input request_t r);
        timing_t     res;
        logic [63:0] rate;
        logic [63:0] ext;
        logic [63:0] hz;
        logic [63:0] khz;
        logic [63:0] secs;
        logic [63:0] rem;
        logic [63:0] ms;
        logic [63:0] us;
        logic [63:0] tot;
        logic [31:0] diff;
        logic [63:0] fixed;
        rate = (rate_setting == '0) ? 64'd1 : {54'd0, rate_setting};
        if (r.sample < last_sample)
            wrap_count = wrap_count + 32'd1;
        last_sample = r.sample;
        res = '0;
        if (r.kind == KIND_TIME)
        begin
            ext  = {wrap_count, r.sample};
            hz   = rate * 64'd1000000;
            khz  = rate * 64'd1000;
            secs = ext / hz;
            rem  = ext - secs * hz;
            ms   = rem / khz;
            rem  = rem - ms * khz;
            us   = rem / rate;
            tot  = secs * 64'd1000000 + ms * 64'd1000 + us;
            res.seconds      = secs[SEC_W-1:0];
            res.milliseconds = ms[PART_W-1:0];
            res.microseconds = us[PART_W-1:0];
            res.total_us     = tot[SAMPLE_W-1:0];
        end
        else
        begin
            diff  = r.sample - r.base;
            fixed = {24'd0, diff, 8'd0} / rate;
            res.delta_cycles   = diff;
            res.delta_us_fixed = fixed[FIX_W-1:0];
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Offer one request and wait for the block to take it
    task automatic offer_request(input request_t r, input logic typed,
                                 input timing_t typed_result);
        timing_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        kind            <= r.kind;
        counter_sample  <= r.sample;
        reference_count <= r.base;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_timebase(r);
        pending_results.push_back(typed ? typed_result : predicted);
        if (r.kind == KIND_TIME)
            time_requests++;
        else
            delta_requests++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_rate(input logic [MHZ_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        clock_mhz <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rate_setting = value;
        rate_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random request shaped like real counter reads: mostly forward steps
    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 40)
            counter_now = counter_now + $urandom_range(200000);
        else if (pick < 75)
            counter_now = counter_now + ($urandom & 32'h3FFF_FFFF);
        else if (pick < 88)
            counter_now = counter_now + $urandom;
        else if (pick < 95)
            counter_now = $urandom;
        // otherwise the counter reads the same value again
        r.kind   = kind_e'($urandom_range(1));
        r.sample = counter_now;
        if ($urandom_range(99) < 80)
            r.base = counter_now - $urandom_range(1000000);
        else
            r.base = $urandom;
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        timing_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_error("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("seconds", 64'(seconds), 64'(want.seconds));
                check_field("milliseconds", 64'(milliseconds),
                            64'(want.milliseconds));
                check_field("microseconds", 64'(microseconds),
                            64'(want.microseconds));
                check_field("total_us", 64'(total_us), 64'(want.total_us));
                check_field("delta_cycles", 64'(delta_cycles),
                            64'(want.delta_cycles));
                check_field("delta_us_fixed", 64'(delta_us_fixed),
                            64'(want.delta_us_fixed));
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("cycle_counter_timebase_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        request_t r;
        int       rate;
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        clock_mhz          = MHZ_RESET;
        in_valid           = 1'b0;
        kind               = 1'b0;
        counter_sample     = '0;
        reference_count    = '0;
        out_stall          = 1'b0;
        last_sample        = '0;
        wrap_count         = '0;
        rate_setting       = MHZ_RESET;
        error_count        = 0;
        time_requests      = 0;
        delta_requests     = 0;
        rate_writes        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 0;
        quiet_cycles       = 0;
        counter_now        = '0;

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table at the reset rate
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            r.kind   = DIRECTED[i].kind;
            r.sample = DIRECTED[i].sample;
            r.base   = DIRECTED[i].base;
            offer_request(r, DIRECTED[i].typed, DIRECTED[i].result);
        end
        drain_results();
        counter_now = last_sample;

        // Random phases, one clock rate and idling pattern each
        for (int p = 0; p < N_PHASES; p++)
        begin
            rate = (PHASE_RATE[p] < 0) ? $urandom_range(999, 2) : PHASE_RATE[p];
            write_rate(rate[MHZ_W-1:0]);
            sender_idle_pct    = PHASE_IDLE[p];
            receiver_stall_pct = PHASE_STALL[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long receiver hold-off so the block backs up its input
                if (p == 0 && i == 5)
                    hold_left = HOLD_CYCLES;
                offer_request(random_request(), 1'b0, ALL_ZERO);
            end
            drain_results();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Run covered %0d time and %0d delta requests across %0d wraps,",
                 time_requests, delta_requests, wrap_count);
        $display("with %0d clock rate writes including 0, 1, 1000 and 1023 MHz.",
                 rate_writes);
        if (error_count == 0)
            $display("cycle_counter_timebase_tb: clean");
        else
            $display("cycle_counter_timebase_tb: errors");
        $finish;
    end

endmodule
